>>> hw/rtl/rsa_pkg.sv
`timescale 1ns / 1ps

package rsa_pkg;

  localparam int MAX_SERVERS = 16;

  localparam int ARRIVAL_W = 31;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 32;
  localparam int ID_W      = 4;
  localparam int CFG_W     = 5;

  localparam logic [CFG_W-1:0]   SERVER_COUNT_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_SAT          = '1;

  localparam logic CMD_DISPATCH = 1'b0;
  localparam logic CMD_REPORT   = 1'b1;

  localparam logic KIND_DISPATCH = 1'b0;
  localparam logic KIND_REPORT   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PICK,
    S_MAX,
    S_MATCH,
    S_EMIT
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [ARRIVAL_W-1:0] arrival;
    logic [TIME_W-1:0]    finish;
    logic [COUNT_W-1:0]   max_all;
  } cell_cmd_t;

  typedef struct packed {
    logic               free;
    logic               match;
    logic [COUNT_W-1:0] count;
  } cell_stat_t;

endpackage

>>> hw/rtl/rsa_cell.sv
`timescale 1ns / 1ps

module rsa_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  rsa_pkg::cell_cmd_t       cmd,
  input  logic                     wr,
  input  logic                     in_use,
  input  logic [rsa_pkg::COUNT_W-1:0] max_in,
  output logic [rsa_pkg::COUNT_W-1:0] max_out,
  output rsa_pkg::cell_stat_t      stat
);
  import rsa_pkg::*;

  logic               busy;
  logic [TIME_W-1:0]  finish;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] max_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (wr) begin
      busy <= 1'b1;
      if (count != COUNT_SAT) begin
        count <= count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      finish <= cmd.finish;
    end
  end

  // running max moves one cell per cycle
  assign max_next = (in_use && (count > max_in)) ? count : max_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_out <= '0;
    end else begin
      max_out <= max_next;
    end
  end

  assign stat.free  = !busy || (finish <= {1'b0, cmd.arrival});
  assign stat.match = in_use && (count == cmd.max_all);
  assign stat.count = count;

endmodule

>>> hw/rtl/rotating_server_assigner.sv
`timescale 1ns / 1ps

// Round-robin dispatcher over a pool of servers, one cell per server.
// Command channel: an item (command, arrival_time, load_time) is taken on a
// rising edge with start high and busy low.
// Dispatch: the chosen server (first free at or above the rotating start
// index, else the lowest free one) is reported after the S_EVAL and S_PICK
// states, with assigned low and id/count zero when every server is busy.
// A new item can be taken in the cycle the result is shown.
// Report: the running maximum of the handled counts ripples down the cell
// row, one cell per cycle, in S_MAX; then S_MATCH marks the matching
// servers, then one beat per matching server follows, ascending id, last
// high on the final beat. busy stays high from accept through the S_MAX,
// S_MATCH and S_EMIT states.
// Results: strobe marks each beat for one cycle; the receiver cannot stall.
// Config: cfg_data (server count) is written on cfg_valid & cfg_ready;
// cfg_ready is high only while idle with start low.
// Reset: all servers idle with zero counts, start index 0, server count 16.
module rotating_server_assigner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command,
  input  logic [rsa_pkg::ARRIVAL_W-1:0] arrival_time,
  input  logic [rsa_pkg::ARRIVAL_W-1:0] load_time,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsa_pkg::CFG_W-1:0]     cfg_data,
  output logic                          strobe,
  output logic                          kind,
  output logic                          assigned,
  output logic [rsa_pkg::ID_W-1:0]      server_num,
  output logic [rsa_pkg::COUNT_W-1:0]   handled_count,
  output logic                          last
);
  import rsa_pkg::*;

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int NW    = $clog2(MAX_SERVERS + 1);
  localparam logic [31:0]      MAX_U32  = 32'(MAX_SERVERS);
  localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(MAX_SERVERS - 1);

  state_t state, state_next;

  logic [CFG_W-1:0]     server_count;
  logic [IDX_W-1:0]     start_index;
  logic [ARRIVAL_W-1:0] arrival_q;
  logic [TIME_W-1:0]    finish_q;
  logic [MAX_SERVERS-1:0] free_q;
  logic [MAX_SERVERS-1:0] remain;
  logic [IDX_W-1:0]     max_cnt;
  logic [COUNT_W-1:0]   max_q;

  logic                 strobe_next;
  logic                 kind_next;
  logic                 assigned_next;
  logic [ID_W-1:0]      server_num_next;
  logic [COUNT_W-1:0]   handled_count_next;
  logic                 last_next;

  logic [31:0]          cnt32;
  logic [31:0]          n32;
  logic [NW-1:0]        n_use;
  logic [IDX_W-1:0]     start_eff;
  logic [IDX_W-1:0]     start_adv;
  logic [MAX_SERVERS-1:0] in_use;
  logic [MAX_SERVERS-1:0] ge_mask;
  logic [MAX_SERVERS-1:0] cand;
  logic [MAX_SERVERS-1:0] cand_hi;
  logic [MAX_SERVERS-1:0] free_vec;
  logic [MAX_SERVERS-1:0] match_vec;
  logic [MAX_SERVERS-1:0] remain_after;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [IDX_W-1:0]     emit_id;
  logic [COUNT_W-1:0]   pick_count;
  logic [COUNT_W-1:0]   pick_count_inc;

  logic                 accept;
  logic                 cap_item;
  logic                 cap_free;
  logic                 do_pick;
  logic                 cnt_run;
  logic                 cap_match;
  logic                 do_emit;

  cell_cmd_t            cmd;
  cell_stat_t           stat [MAX_SERVERS];
  logic [COUNT_W-1:0]   chain [MAX_SERVERS+1];
  logic [MAX_SERVERS-1:0] wr;

  function automatic logic [IDX_W-1:0] lowest_set(input logic [MAX_SERVERS-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

  // servers in use, clamped to 1..MAX_SERVERS
  assign cnt32 = {27'd0, server_count};
  assign n32   = (cnt32 == 32'd0) ? 32'd1 : ((cnt32 > MAX_U32) ? MAX_U32 : cnt32);
  assign n_use = n32[NW-1:0];

  assign start_eff = (NW'(start_index) < n_use) ? start_index : '0;
  assign start_adv = ((NW'(start_eff) + NW'(1)) >= n_use) ? '0 : (start_eff + IDX_W'(1));

  always_comb begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      in_use[i]    = NW'(i) < n_use;
      ge_mask[i]   = IDX_W'(i) >= start_eff;
      free_vec[i]  = stat[i].free;
      match_vec[i] = stat[i].match;
    end
  end

  assign cand    = free_q & in_use;
  assign cand_hi = cand & ge_mask;
  assign found   = |cand;
  assign pick    = (|cand_hi) ? lowest_set(cand_hi) : lowest_set(cand);

  assign pick_count     = stat[pick].count;
  assign pick_count_inc = (pick_count == COUNT_SAT) ? pick_count : pick_count + COUNT_W'(1);

  assign emit_id      = lowest_set(remain);
  assign remain_after = remain & ~(MAX_SERVERS'(1) << emit_id);

  // cell row
  assign cmd.arrival = arrival_q;
  assign cmd.finish  = finish_q;
  assign cmd.max_all = chain[MAX_SERVERS];
  assign chain[0]    = '0;

  always_comb begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      wr[i] = do_pick && found && (pick == IDX_W'(i));
    end
  end

  for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
    rsa_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .wr      (wr[g]),
      .in_use  (in_use[g]),
      .max_in  (chain[g]),
      .max_out (chain[g+1]),
      .stat    (stat[g])
    );
  end

  // control
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (command == CMD_REPORT) ? S_MAX : S_EVAL;
        end
      end
      S_EVAL:  state_next = S_PICK;
      S_PICK:  state_next = S_IDLE;
      S_MAX: begin
        if (max_cnt == CNT_LAST) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: state_next = S_EMIT;
      S_EMIT: begin
        if (remain_after == '0) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    cfg_ready = 1'b0;
    cap_item  = 1'b0;
    cap_free  = 1'b0;
    do_pick   = 1'b0;
    cnt_run   = 1'b0;
    cap_match = 1'b0;
    do_emit   = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy      = 1'b0;
        cfg_ready = !start;
        cap_item  = start;
      end
      S_EVAL:  cap_free  = 1'b1;
      S_PICK:  do_pick   = 1'b1;
      S_MAX:   cnt_run   = 1'b1;
      S_MATCH: cap_match = 1'b1;
      S_EMIT:  do_emit   = 1'b1;
      default: busy      = 1'b1;
    endcase
  end

  always_comb begin
    strobe_next        = 1'b0;
    kind_next          = KIND_DISPATCH;
    assigned_next      = 1'b0;
    server_num_next    = '0;
    handled_count_next = '0;
    last_next          = 1'b1;
    if (do_pick) begin
      strobe_next = 1'b1;
      if (found) begin
        assigned_next      = 1'b1;
        server_num_next    = ID_W'(pick);
        handled_count_next = pick_count_inc;
      end
    end else if (do_emit) begin
      strobe_next        = 1'b1;
      kind_next          = KIND_REPORT;
      server_num_next    = ID_W'(emit_id);
      handled_count_next = max_q;
      last_next          = (remain_after == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      server_count <= SERVER_COUNT_RESET;
      start_index  <= '0;
      max_cnt      <= '0;
      strobe       <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      if (cfg_valid && cfg_ready) begin
        server_count <= cfg_data;
      end
      if (do_pick) begin
        start_index <= start_adv;
      end
      if (cnt_run) begin
        max_cnt <= max_cnt + IDX_W'(1);
      end else begin
        max_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap_item) begin
      arrival_q <= arrival_time;
      finish_q  <= {1'b0, arrival_time} + {1'b0, load_time};
    end
    if (cap_free) begin
      free_q <= free_vec;
    end
    if (cap_match) begin
      remain <= match_vec;
      max_q  <= chain[MAX_SERVERS];
    end else if (do_emit) begin
      remain <= remain_after;
    end
    if (strobe_next) begin
      kind          <= kind_next;
      assigned      <= assigned_next;
      server_num    <= server_num_next;
      handled_count <= handled_count_next;
      last          <= last_next;
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import rsa_pkg::*;

  localparam int POOL = MAX_SERVERS;
  localparam int LIMIT = 200000;
  localparam logic [ARRIVAL_W-1:0] TMAX = '1;

  typedef struct packed {
    logic               kind;
    logic               assigned;
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] count;
    logic               last;
  } outcome_t;

  class pool_tracker;
    logic [TIME_W-1:0]  finish [POOL];
    bit                 engaged [POOL];
    logic [COUNT_W-1:0] served [POOL];
    int unsigned        rot;
    logic [CFG_W-1:0]   count_reg;
    outcome_t           outcomes_due [$];
    int unsigned        errors;

    function new();
      for (int i = 0; i < POOL; i++) begin
        finish[i] = '0;
        engaged[i] = 1'b0;
        served[i] = '0;
      end
      rot = 0;
      count_reg = SERVER_COUNT_RESET;
      errors = 0;
    endfunction

    function int unsigned in_use();
      if (count_reg == 0) return 1;
      if (count_reg > POOL) return POOL;
      return {27'd0, count_reg};
    endfunction

    function void set_count(logic [CFG_W-1:0] v);
      count_reg = v;
    endfunction

    function void take_request(logic cmd, logic [ARRIVAL_W-1:0] arr,
                               logic [ARRIVAL_W-1:0] ld);
      int unsigned n, first, idx, pick, lastid;
      bit found;
      logic [COUNT_W-1:0] top;
      outcome_t o;
      n = in_use();
      o = '0;
      if (cmd == CMD_DISPATCH) begin
        first = (rot < n) ? rot : 0;
        found = 1'b0;
        pick = 0;
        for (int k = 0; k < n; k++) begin
          idx = (first + k) % n;
          if (!found && (!engaged[idx] || finish[idx] <= {1'b0, arr})) begin
            found = 1'b1;
            pick = idx;
          end
        end
        rot = (first + 1 >= n) ? 0 : first + 1;
        o.kind = KIND_DISPATCH;
        o.last = 1'b1;
        if (found) begin
          engaged[pick] = 1'b1;
          finish[pick] = {1'b0, arr} + {1'b0, ld};
          if (served[pick] != COUNT_SAT) served[pick] = served[pick] + COUNT_W'(1);
          o.assigned = 1'b1;
          o.id = pick[ID_W-1:0];
          o.count = served[pick];
        end
        outcomes_due = {outcomes_due, o};
      end else begin
        top = '0;
        lastid = 0;
        for (int k = 0; k < n; k++)
          if (served[k] > top) top = served[k];
        for (int k = 0; k < n; k++)
          if (served[k] == top) lastid = k;
        for (int k = 0; k < n; k++) begin
          if (served[k] == top) begin
            o.kind = KIND_REPORT;
            o.assigned = 1'b0;
            o.id = k[ID_W-1:0];
            o.count = top;
            o.last = (k == lastid);
            outcomes_due = {outcomes_due, o};
          end
        end
      end
    endfunction

    function void check_beat(outcome_t got);
      outcome_t want;
      if (outcomes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got kind=%0d assigned=%0d id=%0d",
                 $time, got.kind, got.assigned, got.id);
        $display("%0t:   count=%0d last=%0d", $time, got.count, got.last);
        return;
      end
      want = outcomes_due.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: beat mismatch, expected kind=%0d assigned=%0d id=%0d count=%0d last=%0d",
                 $time, want.kind, want.assigned, want.id, want.count, want.last);
        $display("%0t:                got      kind=%0d assigned=%0d id=%0d count=%0d last=%0d",
                 $time, got.kind, got.assigned, got.id, got.count, got.last);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 command;
  logic [ARRIVAL_W-1:0] arrival_time;
  logic [ARRIVAL_W-1:0] load_time;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data;
  logic                 strobe;
  logic                 kind;
  logic                 assigned;
  logic [ID_W-1:0]      server_num;
  logic [COUNT_W-1:0]   handled_count;
  logic                 last;

  pool_tracker sb;
  int unsigned cycles = 0;
  logic [ARRIVAL_W-1:0] now;

  rotating_server_assigner uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .arrival_time(arrival_time), .load_time(load_time),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .strobe(strobe), .kind(kind), .assigned(assigned), .server_num(server_num),
    .handled_count(handled_count), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result beats first, then this edge's accepted command and config beats
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe === 1'b1)
        sb.check_beat('{kind, assigned, server_num, handled_count, last});
      if (start && !busy)
        sb.take_request(command, arrival_time, load_time);
      if (cfg_valid && cfg_ready)
        sb.set_count(cfg_data);
    end
  end

  task automatic issue(input logic cmd, input logic [ARRIVAL_W-1:0] arr,
                       input logic [ARRIVAL_W-1:0] ld, input bit idle_ok);
    start <= 1'b1;
    command <= cmd;
    arrival_time <= arr;
    load_time <= ld;
    do @(posedge clk); while (busy);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic set_servers(input logic [CFG_W-1:0] v);
    start <= 1'b0;
    while (sb.outcomes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item(input bit idle_ok);
    logic [ARRIVAL_W-1:0] ld;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      issue(CMD_REPORT, ARRIVAL_W'($urandom), ARRIVAL_W'($urandom), idle_ok);
    end else begin
      if (r < 20) begin
        now = ARRIVAL_W'($urandom);
        ld = ARRIVAL_W'($urandom);
      end else begin
        if (r < 25) now = now - ARRIVAL_W'($urandom_range(1, 50));
        else now = now + ARRIVAL_W'($urandom_range(0, 8));
        ld = ARRIVAL_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 300)
                                                     : $urandom_range(0, 40));
      end
      issue(CMD_DISPATCH, now, ld, idle_ok);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_counts [12];
    phase_counts = '{5'd2, 5'd16, 5'd3, 5'd0, 5'd31, 5'd1,
                     5'd4, 5'd16, 5'd7, 5'd17, 5'd2, 5'd12};
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    command = CMD_DISPATCH;
    arrival_time = '0;
    load_time = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    now = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(CMD_REPORT, '0, '0, 1'b1);
    issue(CMD_DISPATCH, '0, '0, 1'b1);
    issue(CMD_DISPATCH, TMAX, TMAX, 1'b1);
    issue(CMD_DISPATCH, '0, '0, 1'b1);
    issue(CMD_REPORT, TMAX, TMAX, 1'b1);
    set_servers(5'd1);
    issue(CMD_DISPATCH, 31'd5, 31'd100, 1'b1);
    issue(CMD_DISPATCH, 31'd10, 31'd5, 1'b1);
    issue(CMD_DISPATCH, 31'd105, 31'd1, 1'b1);
    issue(CMD_REPORT, '0, '0, 1'b1);
    set_servers(5'd16);
    issue(CMD_DISPATCH, 31'd106, 31'd0, 1'b1);
    repeat (5) issue(CMD_DISPATCH, 31'd200, 31'd1000, 1'b1);
    // start index now past the new count
    set_servers(5'd3);
    issue(CMD_DISPATCH, 31'd300, 31'd0, 1'b1);
    issue(CMD_DISPATCH, 31'd300, 31'd10, 1'b1);
    set_servers(5'd0);
    issue(CMD_DISPATCH, 31'd400, 31'd5, 1'b1);
    issue(CMD_REPORT, '0, '0, 1'b1);
    set_servers(5'd31);
    issue(CMD_DISPATCH, 31'd500, 31'd5, 1'b1);
    issue(CMD_REPORT, '0, '0, 1'b1);

    now = 31'd600;
    for (int p = 0; p < 12; p++) begin
      set_servers(phase_counts[p]);
      repeat (26) random_item(p != 11);
    end
    start <= 1'b0;

    while (sb.outcomes_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rsa_pkg.sv
hw/rtl/rsa_cell.sv
hw/rtl/rotating_server_assigner.sv
dv/tb.sv
